### rtl/core/mfpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfpq_pkg
// Shared types and constants of the meter fault persistence qualifier.
// ----------------------------------------------------------------------------
package mfpq_pkg;

  localparam int unsigned NUM_INPUT_FAULTS = 7;
  localparam int unsigned OUTAGE_CHANNEL   = 4;
  localparam int unsigned PHASE_BIT        = 7;
  localparam int unsigned CFG_COUNT        = 7;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned TRIP_W           = 16;
  localparam int unsigned MASK_W           = 8;
  localparam int unsigned FAIL_W           = 16;

  typedef logic [TRIP_W-1:0] trip_t;

  localparam trip_t TRIP_RESET [CFG_COUNT] = '{
    trip_t'(60), trip_t'(60), trip_t'(60), trip_t'(60),
    trip_t'(180), trip_t'(60), trip_t'(60)
  };

  typedef struct packed {
    logic hit;
    logic latch_nxt;
  } lane_status_t;

  typedef struct packed {
    logic [MASK_W-1:0] new_event_mask;
    logic [MASK_W-1:0] active_fault_mask;
    logic [FAIL_W-1:0] long_failure_count;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/mfpq_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfpq_lane
// One fault channel: saturating persistence counter, trip compare and latch.
// ----------------------------------------------------------------------------
module mfpq_lane #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire logic             flag,
  input  wire mfpq_pkg::trip_t  trip_time,
  output mfpq_pkg::lane_status_t status
);

  localparam int unsigned CMP_W =
    (COUNT_WIDTH > mfpq_pkg::TRIP_W) ? COUNT_WIDTH : mfpq_pkg::TRIP_W;

  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [COUNT_WIDTH-1:0] cnt_nxt;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   latch_r;
  logic                   latch_nxt;
  logic                   trip_hit;

  always_comb begin
    cnt_inc   = (cnt_r == '1) ? cnt_r : cnt_r + COUNT_WIDTH'(1);
    trip_hit  = flag && (CMP_W'(cnt_inc) >= CMP_W'(trip_time));
    cnt_nxt   = flag ? cnt_inc : '0;
    latch_nxt = flag && (latch_r || trip_hit);
    status.hit       = trip_hit && !latch_r;
    status.latch_nxt = latch_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      latch_r <= 1'b0;
    end else if (advance) begin
      cnt_r   <= cnt_nxt;
      latch_r <= latch_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mfpq_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfpq_merge
// Combines the lane results with the phase reversal latch into the event and
// fault masks, and keeps the saturating count of long power failures.
// ----------------------------------------------------------------------------
module mfpq_merge (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   advance,
  input  wire logic                   phase_flag,
  input  wire mfpq_pkg::lane_status_t status [mfpq_pkg::NUM_INPUT_FAULTS],
  output mfpq_pkg::result_t           result
);

  logic                          phase_r;
  logic [mfpq_pkg::FAIL_W-1:0]   fail_cnt_r;
  logic [mfpq_pkg::FAIL_W-1:0]   fail_cnt_nxt;

  always_comb begin
    result.new_event_mask    = '0;
    result.active_fault_mask = '0;
    for (int i = 0; i < mfpq_pkg::NUM_INPUT_FAULTS; i++) begin
      result.new_event_mask[i]    = status[i].hit;
      result.active_fault_mask[i] = status[i].latch_nxt;
    end
    result.new_event_mask[mfpq_pkg::PHASE_BIT]    = phase_flag && !phase_r;
    result.active_fault_mask[mfpq_pkg::PHASE_BIT] = phase_flag;

    fail_cnt_nxt = fail_cnt_r;
    if (status[mfpq_pkg::OUTAGE_CHANNEL].hit && (fail_cnt_r != '1)) begin
      fail_cnt_nxt = fail_cnt_r + mfpq_pkg::FAIL_W'(1);
    end
    result.long_failure_count = fail_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= 1'b0;
      fail_cnt_r <= '0;
    end else if (advance) begin
      phase_r    <= phase_flag;
      fail_cnt_r <= fail_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/meter_fault_persistence_qualifier.sv
`timescale 1ns / 1ps
`default_nettype none
// A request's result is written into the output queue when it is accepted.
// Throughput: one request per cycle while the output queue is not full; all fault lanes update in parallel.
// A two-entry output queue lets a request enter while a result still waits.
// Reset (synchronous, active low) clears counters, latches, the failure count
// and the queue, and loads the default trip times.
// ----------------------------------------------------------------------------
// meter_fault_persistence_qualifier
// Qualifies per-second fault flags by persistence and raises latch events.
// ----------------------------------------------------------------------------
module meter_fault_persistence_qualifier #(
  parameter int unsigned FAULT_CHANNELS = 7,
  parameter int unsigned COUNT_WIDTH    = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,

  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic                            in_active_power_high,
  input  wire logic                            in_current_high,
  input  wire logic                            in_voltage_high,
  input  wire logic                            in_voltage_low,
  input  wire logic                            in_power_failed,
  input  wire logic                            in_frequency_high,
  input  wire logic                            in_frequency_low,
  input  wire logic                            in_phase_reversed,

  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [mfpq_pkg::MASK_W-1:0]     out_new_event_mask,
  output      logic [mfpq_pkg::MASK_W-1:0]     out_active_fault_mask,
  output      logic [mfpq_pkg::FAIL_W-1:0]     out_long_failure_count,

  input  wire logic                            cfg_wr_en,
  input  wire logic [mfpq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mfpq_pkg::TRIP_W-1:0]     cfg_wdata
);

  mfpq_pkg::trip_t                trip_r [mfpq_pkg::CFG_COUNT];
  logic [mfpq_pkg::NUM_INPUT_FAULTS-1:0] in_flags;
  mfpq_pkg::lane_status_t         lane_status [mfpq_pkg::NUM_INPUT_FAULTS];
  mfpq_pkg::result_t              result;
  logic                           push;
  logic                           pop;

  mfpq_pkg::result_t              q0_r, q0_nxt;
  mfpq_pkg::result_t              q1_r, q1_nxt;
  logic [1:0]                     cnt_r, cnt_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mfpq_pkg::CFG_COUNT; i++) begin
        trip_r[i] <= mfpq_pkg::TRIP_RESET[i];
      end
    end else if (cfg_wr_en && (32'(cfg_index) < mfpq_pkg::CFG_COUNT)) begin
      trip_r[cfg_index] <= cfg_wdata;
    end
  end

  assign in_flags = {in_frequency_low, in_frequency_high, in_power_failed,
                     in_voltage_low, in_voltage_high, in_current_high,
                     in_active_power_high};

  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  for (genvar g = 0; g < mfpq_pkg::NUM_INPUT_FAULTS; g++) begin : g_lane
    if (g < FAULT_CHANNELS) begin : g_used
      mfpq_lane #(
        .COUNT_WIDTH (COUNT_WIDTH)
      ) u_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (push),
        .flag      (in_flags[g]),
        .trip_time (trip_r[g]),
        .status    (lane_status[g])
      );
    end else begin : g_absent
      assign lane_status[g] = '0;
    end
  end

  mfpq_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (push),
    .phase_flag (in_phase_reversed),
    .status     (lane_status),
    .result     (result)
  );

  // Two-entry output queue; q0 is the head.
  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
    if (pop) begin
      q0_nxt = (cnt_r == 2'd2) ? q1_r : result;
    end else if (cnt_r == 2'd0) begin
      q0_nxt = result;
    end
    if (push && (cnt_r == 2'd1) && !pop) begin
      q1_nxt = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign in_ready               = (cnt_r != 2'd2);
  assign out_valid              = (cnt_r != 2'd0);
  assign out_new_event_mask     = q0_r.new_event_mask;
  assign out_active_fault_mask  = q0_r.active_fault_mask;
  assign out_long_failure_count = q0_r.long_failure_count;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output queue count out of range");

  a_full_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("queue full with no valid output");

  a_event_is_latched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_new_event_mask & ~out_active_fault_mask) == '0))
    else $error("event raised for a fault that is not latched");

  a_fail_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (result.long_failure_count >= $past(result.long_failure_count)))
    else $error("long failure count decreased");

endmodule

`default_nettype wire

### tb/meter_fault_persistence_qualifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Meter fault persistence qualifier testbench
// Drives per-second fault ticks through the request channel, and programs the
// trip times between phases. Each result is compared with a local model of the
// persistence counters, fault latches and long outage count. The run covers
// directed corner cases, input backpressure, and random flag runs. It ends
// with a run of alternating power failures that counts long outages.
// ----------------------------------------------------------------------------
module meter_fault_persistence_qualifier_test;

  localparam int IDLE_PCT      = 37;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int COUNT_W       = 16;
  localparam int OUTAGE_TICKS  = 40;
  localparam int RANDOM_PHASES = 4;

  localparam logic [mfpq_pkg::MASK_W-1:0] ALL_FAULTS        = 8'h7F;
  localparam logic [mfpq_pkg::MASK_W-1:0] ACTIVE_POWER_FLAG = 8'h01;
  localparam logic [mfpq_pkg::MASK_W-1:0] CURRENT_FLAG      = 8'h02;
  localparam logic [mfpq_pkg::MASK_W-1:0] OUTAGE_FLAG       =
    8'h01 << mfpq_pkg::OUTAGE_CHANNEL;
  localparam logic [mfpq_pkg::MASK_W-1:0] PHASE_FLAG        =
    8'h01 << mfpq_pkg::PHASE_BIT;

  typedef enum logic [mfpq_pkg::CFG_IDX_W-1:0] {
    REG_ACTIVE_POWER_TRIP,
    REG_OVER_CURRENT_TRIP,
    REG_OVER_VOLTAGE_TRIP,
    REG_UNDER_VOLTAGE_TRIP,
    REG_LONG_OUTAGE_TRIP,
    REG_OVER_FREQ_TRIP,
    REG_UNDER_FREQ_TRIP,
    REG_UNUSED
  } trip_reg_e;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_active_power_high;
  logic in_current_high;
  logic in_voltage_high;
  logic in_voltage_low;
  logic in_power_failed;
  logic in_frequency_high;
  logic in_frequency_low;
  logic in_phase_reversed;
  logic out_valid;
  logic out_ready;
  logic [mfpq_pkg::MASK_W-1:0] out_new_event_mask;
  logic [mfpq_pkg::MASK_W-1:0] out_active_fault_mask;
  logic [mfpq_pkg::FAIL_W-1:0] out_long_failure_count;
  logic cfg_wr_en;
  logic [mfpq_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mfpq_pkg::TRIP_W-1:0] cfg_wdata;

  mfpq_pkg::trip_t trip_setting [mfpq_pkg::CFG_COUNT];
  logic [COUNT_W-1:0] persist_count [mfpq_pkg::NUM_INPUT_FAULTS];
  logic [mfpq_pkg::MASK_W-1:0] latched_mask;
  logic [mfpq_pkg::FAIL_W-1:0] long_outages;

  mfpq_pkg::result_t pending_results [$];
  int mismatches;
  int stall_left;
  int quiet_cycles;
  bit calm;

  meter_fault_persistence_qualifier dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_active_power_high   (in_active_power_high),
    .in_current_high        (in_current_high),
    .in_voltage_high        (in_voltage_high),
    .in_voltage_low         (in_voltage_low),
    .in_power_failed        (in_power_failed),
    .in_frequency_high      (in_frequency_high),
    .in_frequency_low       (in_frequency_low),
    .in_phase_reversed      (in_phase_reversed),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_new_event_mask     (out_new_event_mask),
    .out_active_fault_mask  (out_active_fault_mask),
    .out_long_failure_count (out_long_failure_count),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_fault_model();
    for (int r = 0; r < mfpq_pkg::CFG_COUNT; r++) begin
      trip_setting[r] = mfpq_pkg::TRIP_RESET[r];
    end
    for (int ch = 0; ch < mfpq_pkg::NUM_INPUT_FAULTS; ch++) begin
      persist_count[ch] = '0;
    end
    latched_mask = '0;
    long_outages = '0;
  endfunction

  function automatic mfpq_pkg::result_t qualify_tick(
    input logic [mfpq_pkg::MASK_W-1:0] flags
  );
    mfpq_pkg::result_t res;
    logic [mfpq_pkg::MASK_W-1:0] events;
    events = '0;
    for (int ch = 0; ch < mfpq_pkg::NUM_INPUT_FAULTS; ch++) begin
      if (flags[ch]) begin
        if (persist_count[ch] != '1) begin
          persist_count[ch] = persist_count[ch] + 1'b1;
        end
        if (persist_count[ch] >= trip_setting[ch] && !latched_mask[ch]) begin
          latched_mask[ch] = 1'b1;
          events[ch] = 1'b1;
          if (ch == mfpq_pkg::OUTAGE_CHANNEL && long_outages != '1) begin
            long_outages = long_outages + 1'b1;
          end
        end
      end else begin
        persist_count[ch] = '0;
        latched_mask[ch] = 1'b0;
      end
    end
    if (flags[mfpq_pkg::PHASE_BIT]) begin
      if (!latched_mask[mfpq_pkg::PHASE_BIT]) begin
        latched_mask[mfpq_pkg::PHASE_BIT] = 1'b1;
        events[mfpq_pkg::PHASE_BIT] = 1'b1;
      end
    end else begin
      latched_mask[mfpq_pkg::PHASE_BIT] = 1'b0;
    end
    res.new_event_mask = events;
    res.active_fault_mask = latched_mask;
    res.long_failure_count = long_outages;
    return res;
  endfunction

  task automatic send_tick(input logic [mfpq_pkg::MASK_W-1:0] flags);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    {in_phase_reversed, in_frequency_low, in_frequency_high, in_power_failed,
     in_voltage_low, in_voltage_high, in_current_high, in_active_power_high} = flags;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    pending_results.push_back(qualify_tick(flags));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_trip(input trip_reg_e reg_idx, input mfpq_pkg::trip_t value);
    cfg_wr_en = 1'b1;
    cfg_index = reg_idx;
    cfg_wdata = value;
    if (reg_idx < mfpq_pkg::CFG_COUNT) begin
      trip_setting[reg_idx] = value;
    end
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic mfpq_pkg::trip_t pick_trip();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return mfpq_pkg::trip_t'($urandom());
      default: return mfpq_pkg::trip_t'($urandom_range(6, 1));
    endcase
  endfunction

  task automatic test_reset_trip_times();
    send_tick('0);
    send_tick(PHASE_FLAG);
    send_tick(PHASE_FLAG);
    send_tick('1);
    send_tick('0);
    wait_drained();
  endtask

  task automatic test_programmed_trip_times();
    for (int r = 0; r < mfpq_pkg::CFG_COUNT; r++) begin
      write_trip(trip_reg_e'(r), mfpq_pkg::trip_t'(r));
    end
    write_trip(REG_UNUSED, '0);
    repeat (8) send_tick(ALL_FAULTS | PHASE_FLAG);
    send_tick('0);
    send_tick(ALL_FAULTS);
    wait_drained();
  endtask

  task automatic test_trip_extremes();
    for (int r = 0; r < mfpq_pkg::CFG_COUNT; r++) begin
      write_trip(trip_reg_e'(r), '1);
    end
    repeat (3) send_tick(ALL_FAULTS);
    wait_drained();
    for (int r = 0; r < mfpq_pkg::CFG_COUNT; r++) begin
      write_trip(trip_reg_e'(r), '0);
    end
    send_tick(ALL_FAULTS);
    send_tick('0);
    send_tick('1);
    wait_drained();
  endtask

  task automatic test_input_backpressure();
    calm = 1'b1;
    stall_left = 60;
    for (int n = 0; n < 20; n++) begin
      send_tick(8'($urandom()));
    end
    calm = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_ticks();
    logic [mfpq_pkg::MASK_W-1:0] held;
    held = '0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      for (int r = 0; r < mfpq_pkg::CFG_COUNT; r++) begin
        write_trip(trip_reg_e'(r), pick_trip());
      end
      calm = (phase == 2);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(9) == 0) begin
          send_tick(8'($urandom()));
        end else begin
          for (int b = 0; b < mfpq_pkg::MASK_W; b++) begin
            if ($urandom_range(5) == 0) begin
              held[b] = ~held[b];
            end
          end
          send_tick(held);
        end
      end
    end
    calm = 1'b0;
    wait_drained();
  endtask

  // Power failure toggles every tick with a zero trip time, so every second
  // tick latches a long outage, while active power and over current stay set
  // and latch once their short trip times have passed.
  task automatic test_outage_counting();
    write_trip(REG_ACTIVE_POWER_TRIP, mfpq_pkg::trip_t'(3));
    write_trip(REG_OVER_CURRENT_TRIP, mfpq_pkg::trip_t'(5));
    write_trip(REG_LONG_OUTAGE_TRIP, '0);
    calm = 1'b1;
    for (int n = 0; n < OUTAGE_TICKS; n++) begin
      send_tick(ACTIVE_POWER_FLAG | CURRENT_FLAG | (n[0] ? OUTAGE_FLAG : 8'h00));
    end
    calm = 1'b0;
    wait_drained();
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic check_field(input string field, input logic [15:0] want, got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    mfpq_pkg::result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %0h %0h %0h", $time,
                 out_new_event_mask, out_active_fault_mask, out_long_failure_count);
      end else begin
        want = pending_results.pop_front();
        check_field("new_event_mask", 16'(want.new_event_mask), 16'(out_new_event_mask));
        check_field("active_fault_mask", 16'(want.active_fault_mask),
                    16'(out_active_fault_mask));
        check_field("long_failure_count", want.long_failure_count, out_long_failure_count);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    stall_left = 0;
    quiet_cycles = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_phase_reversed, in_frequency_low, in_frequency_high, in_power_failed,
     in_voltage_low, in_voltage_high, in_current_high, in_active_power_high} = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_ACTIVE_POWER_TRIP;
    cfg_wdata = '0;
    clear_fault_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_trip_times();
    test_programmed_trip_times();
    test_trip_extremes();
    test_input_backpressure();
    test_random_ticks();
    test_outage_counting();

    wait_drained();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/mfpq_pkg.sv
rtl/core/mfpq_lane.sv
rtl/core/mfpq_merge.sv
rtl/core/meter_fault_persistence_qualifier.sv
tb/meter_fault_persistence_qualifier_test.sv
